/* rtl/core/sbu_pkg.sv */
// shared constants for the separable bilinear upscaler
package sbu_pkg;

	localparam int ROW_W = 12;
	localparam int COL_W = 12;
	localparam int PIX_W = 8;
	localparam int STEP_W = 17;
	localparam int SRC_DIM_W = 10;
	localparam int OUT_DIM_W = 12;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 17;
	// position times inverse step
	localparam int PROD_W = ROW_W + STEP_W;

	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALED_WIDTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALED_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_STEP = 3'd4;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [SRC_DIM_W-1:0] SOURCE_DIM_RESET = 10'd512;
	localparam logic [OUT_DIM_W-1:0] SCALED_DIM_RESET = 12'd512;
	localparam logic [STEP_W-1:0] INVERSE_STEP_RESET = 17'd65536;

endpackage

/* rtl/core/sbu_bank.sv */
// one parity bank of the frame store, one write and one registered read port
module sbu_bank import sbu_pkg::*; #(
	parameter int ADDR_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [PIX_W-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [PIX_W-1:0]  rdata
);

	logic [PIX_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/core/separable_bilinear_upscaler_top.sv */
// top level of the separable bilinear upscaler
//
// Input channel (in_valid / in_stall) takes one item per cycle unless stalled.
// cmd load writes source_pixel at (pos_row, pos_col) of the frame store and
// gives no result; loads outside the store are dropped. cmd query asks for one
// upscaled pixel at output position (pos_row, pos_col) and gives exactly one
// result on the output channel (out_valid / out_stall): the pixel, or zero with
// outside_flag set. The frame store is four row/column parity banks, so the
// four neighbors of a query are read in the same cycle. Accepted items pass the
// stages multiply, bank read, horizontal blend and vertical blend to out_valid;
// throughput is one item per cycle while out_stall is low.
// When out_stall is high the pipeline fills up behind the held result; bubbles
// are squeezed out and in_stall rises only when every stage is full.
// Reset clears all valid bits and returns the registers to their reset values;
// the frame store is not cleared and must be loaded before it is queried.
// The user must make configuration writes on cfg_valid / cfg_ready (always ready)
// only while no item is in flight; the block itself does not enforce this.
module separable_bilinear_upscaler_top import sbu_pkg::*; #(
	parameter int MAX_WIDTH = 512,
	parameter int MAX_HEIGHT = 512,
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  cmd,
	input  logic [ROW_W-1:0]      pos_row,
	input  logic [COL_W-1:0]      pos_col,
	input  logic [PIX_W-1:0]      source_pixel,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIX_W-1:0]      scaled_pixel,
	output logic                  outside_flag
);

	localparam int IW = PROD_W - FRAC_BITS;
	localparam int RAW = (MAX_HEIGHT > 2) ? $clog2((MAX_HEIGHT + 1) / 2) : 1;
	localparam int CAW = (MAX_WIDTH > 2) ? $clog2((MAX_WIDTH + 1) / 2) : 1;
	localparam int AW = RAW + CAW;
	localparam int SUM_W = FRAC_BITS + PIX_W + 1;

	// configuration registers
	logic [SRC_DIM_W-1:0] src_w_q, src_h_q;
	logic [OUT_DIM_W-1:0] out_w_q, out_h_q;
	logic [STEP_W-1:0]    step_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SOURCE_DIM_RESET;
			src_h_q <= SOURCE_DIM_RESET;
			out_w_q <= SCALED_DIM_RESET;
			out_h_q <= SCALED_DIM_RESET;
			step_q  <= INVERSE_STEP_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SOURCE_WIDTH:  src_w_q <= cfg_data[SRC_DIM_W-1:0];
				CFG_SOURCE_HEIGHT: src_h_q <= cfg_data[SRC_DIM_W-1:0];
				CFG_SCALED_WIDTH:  out_w_q <= cfg_data[OUT_DIM_W-1:0];
				CFG_SCALED_HEIGHT: out_h_q <= cfg_data[OUT_DIM_W-1:0];
				CFG_INVERSE_STEP:  step_q  <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// stage enables, a stage moves when it is empty or its successor moves
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4 = !v_s4 || !out_stall;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;

	// stage 1: position products and range checks
	logic                cmd_s1, out_s1, last_s1;
	logic [ROW_W-1:0]    row_s1;
	logic [COL_W-1:0]    col_s1;
	logic [PIX_W-1:0]    pix_s1;
	logic [PROD_W-1:0]   prow_s1, pcol_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			cmd_s1  <= cmd;
			row_s1  <= pos_row;
			col_s1  <= pos_col;
			pix_s1  <= source_pixel;
			prow_s1 <= PROD_W'(pos_row) * PROD_W'(step_q);
			pcol_s1 <= PROD_W'(pos_col) * PROD_W'(step_q);
			out_s1  <= (pos_row >= out_h_q) || (pos_col >= out_w_q);
			last_s1 <= ((OUT_DIM_W + 1)'(pos_row) + 1'b1) == (OUT_DIM_W + 1)'(out_h_q);
		end
	end

	// neighbor indexes and bank addresses
	logic [IW-1:0]        r0, c0;
	logic [IW:0]          r1, c1;
	logic                 ok_t, ok_b, ok_l, ok_r;
	logic [RAW-1:0]       row_even, row_odd;
	logic [CAW-1:0]       col_even, col_odd;
	logic                 wr_ok;

	assign r0 = prow_s1[PROD_W-1:FRAC_BITS];
	assign c0 = pcol_s1[PROD_W-1:FRAC_BITS];
	assign r1 = (IW + 1)'(r0) + 1'b1;
	assign c1 = (IW + 1)'(c0) + 1'b1;

	assign ok_t = (32'(r0) < 32'(src_h_q)) && (32'(r0) < 32'(MAX_HEIGHT));
	assign ok_b = (32'(r1) < 32'(src_h_q)) && (32'(r1) < 32'(MAX_HEIGHT)) && !last_s1;
	assign ok_l = (32'(c0) < 32'(src_w_q)) && (32'(c0) < 32'(MAX_WIDTH));
	assign ok_r = (32'(c1) < 32'(src_w_q)) && (32'(c1) < 32'(MAX_WIDTH));

	// the even row of the pair is r0 or r0 + 1, both halve to the same place
	assign row_even = RAW'(r1 >> 1);
	assign row_odd  = RAW'(r0 >> 1);
	assign col_even = CAW'(c1 >> 1);
	assign col_odd  = CAW'(c0 >> 1);

	assign wr_ok = v_s1 && (cmd_s1 == CMD_LOAD) && en2
		&& (32'(row_s1) < 32'(MAX_HEIGHT)) && (32'(col_s1) < 32'(MAX_WIDTH));

	logic [PIX_W-1:0] rd_s2 [4];

	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic RP = 1'(b >> 1);
		localparam logic CP = 1'(b);
		logic          we;
		logic [AW-1:0] waddr, raddr;

		assign we = wr_ok && (row_s1[0] == RP) && (col_s1[0] == CP);
		assign waddr = {RAW'(row_s1 >> 1), CAW'(col_s1 >> 1)};
		assign raddr = {(RP ? row_odd : row_even), (CP ? col_odd : col_even)};

		sbu_bank #(
			.ADDR_W(AW)
		) u_bank (
			.clk   (clk),
			.we    (we),
			.waddr (waddr),
			.wdata (pix_s1),
			.re    (en2),
			.raddr (raddr),
			.rdata (rd_s2[b])
		);
	end

	// stage 2: bank data is here
	logic                 out_s2, ok_t_s2, ok_b_s2, ok_l_s2, ok_r_s2, rp_s2, cp_s2;
	logic [FRAC_BITS-1:0] fr_s2, fc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1 && (cmd_s1 == CMD_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			out_s2  <= out_s1;
			ok_t_s2 <= ok_t;
			ok_b_s2 <= ok_b;
			ok_l_s2 <= ok_l;
			ok_r_s2 <= ok_r;
			rp_s2   <= r0[0];
			cp_s2   <= c0[0];
			fr_s2   <= prow_s1[FRAC_BITS-1:0];
			fc_s2   <= pcol_s1[FRAC_BITS-1:0];
		end
	end

	logic [PIX_W-1:0]   tl, tr, bl, br;
	logic [FRAC_BITS:0] wc0;
	logic [SUM_W-1:0]   sum_up, sum_lo;

	assign tl = (ok_t_s2 && ok_l_s2) ? rd_s2[{rp_s2, cp_s2}] : '0;
	assign tr = (ok_t_s2 && ok_r_s2) ? rd_s2[{rp_s2, !cp_s2}] : '0;
	assign bl = (ok_b_s2 && ok_l_s2) ? rd_s2[{!rp_s2, cp_s2}] : '0;
	assign br = (ok_b_s2 && ok_r_s2) ? rd_s2[{!rp_s2, !cp_s2}] : '0;

	assign wc0 = (FRAC_BITS + 1)'(1 << FRAC_BITS) - (FRAC_BITS + 1)'(fc_s2);
	assign sum_up = SUM_W'(wc0) * SUM_W'(tl) + SUM_W'(fc_s2) * SUM_W'(tr);
	assign sum_lo = SUM_W'(wc0) * SUM_W'(bl) + SUM_W'(fc_s2) * SUM_W'(br);

	// stage 3: horizontal results
	logic                 out_s3;
	logic [PIX_W-1:0]     up_s3, lo_s3;
	logic [FRAC_BITS-1:0] fr_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			out_s3 <= out_s2;
			up_s3  <= sum_up[FRAC_BITS +: PIX_W];
			lo_s3  <= sum_lo[FRAC_BITS +: PIX_W];
			fr_s3  <= fr_s2;
		end
	end

	logic [FRAC_BITS:0] wr0;
	logic [SUM_W-1:0]   sum_v;

	assign wr0 = (FRAC_BITS + 1)'(1 << FRAC_BITS) - (FRAC_BITS + 1)'(fr_s3);
	assign sum_v = SUM_W'(wr0) * SUM_W'(up_s3) + SUM_W'(fr_s3) * SUM_W'(lo_s3);

	// stage 4: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			outside_flag <= out_s3;
			scaled_pixel <= out_s3 ? '0 : sum_v[FRAC_BITS +: PIX_W];
		end
	end

	assign out_valid = v_s4;

endmodule

/* verif/tb_separable_bilinear_upscaler_top.sv */
// testbench for the separable bilinear upscaler: directed table, then random phases
`timescale 1ns / 1ps

module tb_separable_bilinear_upscaler_top;
	import sbu_pkg::*;

	localparam int MAX_W = 512;
	localparam int MAX_H = 512;
	localparam int FRAC = 16;
	localparam longint unsigned UNIT = 64'd1 << FRAC;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 12;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic cmd;
	logic [ROW_W-1:0] pos_row;
	logic [COL_W-1:0] pos_col;
	logic [PIX_W-1:0] source_pixel;
	logic out_valid;
	logic out_stall;
	logic [PIX_W-1:0] scaled_pixel;
	logic outside_flag;

	separable_bilinear_upscaler_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.pos_row(pos_row),
		.pos_col(pos_col),
		.source_pixel(source_pixel),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.scaled_pixel(scaled_pixel),
		.outside_flag(outside_flag)
	);

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic flag;
	} scaled_t;

	typedef struct {
		logic op;
		int row;
		int col;
		int pix;
		bit typed;
		scaled_t want;
	} table_row_t;

	// mirror of the block state
	bit [7:0] shadow_img [MAX_W*MAX_H];
	bit [SRC_DIM_W-1:0] m_src_w;
	bit [SRC_DIM_W-1:0] m_src_h;
	bit [OUT_DIM_W-1:0] m_out_w;
	bit [OUT_DIM_W-1:0] m_out_h;
	bit [STEP_W-1:0] m_step;

	scaled_t pending_pixels[$];
	int mismatches;
	int idle_cycles;
	int items_sent;
	int results_seen;
	int stall_left;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic longint unsigned pixel_at(longint unsigned r, longint unsigned c);
		longint unsigned uw;
		longint unsigned uh;
		uw = (m_src_w < MAX_W) ? m_src_w : MAX_W;
		uh = (m_src_h < MAX_H) ? m_src_h : MAX_H;
		if (r >= uh || c >= uw)
			return 0;
		return shadow_img[r*MAX_W + c];
	endfunction

	function automatic longint unsigned lerp8(longint unsigned a, longint unsigned b,
			longint unsigned f);
		return (((UNIT - f) * a + f * b) >> FRAC) & 64'hff;
	endfunction

	function automatic longint unsigned row_lerp(longint unsigned r, longint unsigned ocol);
		longint unsigned p;
		p = ocol * m_step;
		return lerp8(pixel_at(r, p >> FRAC), pixel_at(r, (p >> FRAC) + 1), p & (UNIT - 1));
	endfunction

	function automatic scaled_t upscale_pixel(longint unsigned row, longint unsigned col);
		scaled_t res;
		longint unsigned p;
		longint unsigned top_val;
		longint unsigned bot_val;
		res.flag = 1'b0;
		res.pixel = '0;
		if (row >= m_out_h || col >= m_out_w) begin
			res.flag = 1'b1;
			return res;
		end
		p = row * m_step;
		top_val = row_lerp(p >> FRAC, col);
		bot_val = (row + 1 == m_out_h) ? 0 : row_lerp((p >> FRAC) + 1, col);
		res.pixel = lerp8(top_val, bot_val, p & (UNIT - 1));
		return res;
	endfunction

	// apply an accepted item to the mirror, queue the pixel it should produce
	task automatic take_item(logic op, int row, int col, int pix, bit typed, scaled_t want);
		if (op == CMD_LOAD) begin
			if (row < MAX_H && col < MAX_W)
				shadow_img[row*MAX_W + col] = pix[7:0];
		end else if (typed) begin
			pending_pixels.push_back(want);
		end else begin
			pending_pixels.push_back(upscale_pixel(row, col));
		end
	endtask

	task automatic send_item(logic op, int row, int col, int pix, bit typed, scaled_t want);
		int gap;
		gap = (items_sent % 300 < 60) ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		pos_row <= row[ROW_W-1:0];
		pos_col <= col[COL_W-1:0];
		source_pixel <= pix[PIX_W-1:0];
		do @(posedge clk); while (in_stall);
		items_sent++;
		take_item(op, row, col, pix, typed, want);
	endtask

	task automatic settle;
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		// loads may still be in the pipe
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_geometry(int sw, int sh, int ow, int oh, int step);
		int vals [5];
		vals = '{sw, sh, ow, oh, step};
		for (int i = 0; i < 5; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= i[CFG_IDX_W-1:0];
			cfg_data <= vals[i][CFG_DATA_W-1:0];
			do @(posedge clk); while (!cfg_ready);
			case (i[CFG_IDX_W-1:0])
				CFG_SOURCE_WIDTH: m_src_w = vals[i][SRC_DIM_W-1:0];
				CFG_SOURCE_HEIGHT: m_src_h = vals[i][SRC_DIM_W-1:0];
				CFG_SCALED_WIDTH: m_out_w = vals[i][OUT_DIM_W-1:0];
				CFG_SCALED_HEIGHT: m_out_h = vals[i][OUT_DIM_W-1:0];
				CFG_INVERSE_STEP: m_step = vals[i][STEP_W-1:0];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// loads the whole readable region, then random queries mixed with loads
	task automatic run_phase(int sw, int sh, int ow, int oh, int step, int n);
		scaled_t none;
		int uw;
		int uh;
		int r;
		int c;
		int sel;
		none = '0;
		set_geometry(sw, sh, ow, oh, step);
		uw = (sw < MAX_W) ? sw : MAX_W;
		uh = (sh < MAX_H) ? sh : MAX_H;
		for (int y = 0; y < uh; y++)
			for (int x = 0; x < uw; x++)
				send_item(CMD_LOAD, y, x, $urandom_range(0, 255), 1'b0, none);
		for (int k = 0; k < n; k++) begin
			sel = $urandom_range(0, 99);
			if (sel < 10) begin
				send_item(CMD_LOAD, $urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 255), 1'b0, none);
			end else if (sel < 18 && uw > 0 && uh > 0) begin
				send_item(CMD_LOAD, $urandom_range(0, uh - 1), $urandom_range(0, uw - 1),
					$urandom_range(0, 255), 1'b0, none);
			end else begin
				r = (sel < 85) ? $urandom_range(0, oh - 1) : $urandom_range(0, 4095);
				c = (sel % 7 != 0) ? $urandom_range(0, ow - 1) : $urandom_range(0, 4095);
				if (sel >= 95)
					r = oh - 1;
				send_item(CMD_QUERY, r, c, $urandom_range(0, 255), 1'b0, none);
			end
		end
		settle();
	endtask

	// result side: random stalls with calm stretches, compare in order
	always @(posedge clk or negedge arst_n) begin
		scaled_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (pending_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result pixel=%0d flag=%0b", scaled_pixel,
							outside_flag);
				end else begin
					want = pending_pixels.pop_front();
					if (scaled_pixel !== want.pixel || outside_flag !== want.flag) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected pixel=%0d flag=%0b, got pixel=%0d flag=%0b",
								want.pixel, want.flag, scaled_pixel, outside_flag);
					end
				end
				stall_left = (results_seen % 256 < 64) ? 0 : $urandom_range(0, 8);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		table_row_t dir_rows [$];
		mismatches = 0;
		idle_cycles = 0;
		items_sent = 0;
		results_seen = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = CMD_LOAD;
		pos_row = '0;
		pos_col = '0;
		source_pixel = '0;
		m_src_w = SOURCE_DIM_RESET;
		m_src_h = SOURCE_DIM_RESET;
		m_out_w = SCALED_DIM_RESET;
		m_out_h = SCALED_DIM_RESET;
		m_step = INVERSE_STEP_RESET;

		// reset geometry; only the bottom right corner is ever read
		dir_rows = '{
			'{CMD_LOAD, 4095, 4095, 8'haa, 1'b0, '0},
			'{CMD_LOAD, 512, 0, 8'h55, 1'b0, '0},
			'{CMD_LOAD, 0, 512, 8'h55, 1'b0, '0},
			'{CMD_LOAD, 511, 511, 255, 1'b0, '0},
			'{CMD_QUERY, 511, 511, 0, 1'b1, '{8'd255, 1'b0}},
			'{CMD_LOAD, 511, 511, 0, 1'b0, '0},
			'{CMD_QUERY, 511, 511, 255, 1'b1, '{8'd0, 1'b0}},
			'{CMD_QUERY, 512, 0, 0, 1'b1, '{8'd0, 1'b1}},
			'{CMD_QUERY, 0, 512, 0, 1'b1, '{8'd0, 1'b1}},
			'{CMD_QUERY, 4095, 4095, 255, 1'b1, '{8'd0, 1'b1}},
			'{CMD_QUERY, 4095, 0, 255, 1'b1, '{8'd0, 1'b1}},
			'{CMD_QUERY, 0, 4095, 0, 1'b1, '{8'd0, 1'b1}},
			'{CMD_LOAD, 2048, 2048, 8'hff, 1'b0, '0}
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].op, dir_rows[i].row, dir_rows[i].col, dir_rows[i].pix,
				dir_rows[i].typed, dir_rows[i].want);
		settle();

		run_phase(8, 6, 16, 12, 32768, 150);
		run_phase(1, 1, 1, 1, 65536, 40);
		run_phase(512, 1, 4095, 8, 8192, 80);
		run_phase(1, 512, 1, 512, 65536, 80);
		run_phase(5, 4, 40, 32, 8192, 80);
		run_phase(7, 7, 9, 9, 50000, 60);
		run_phase(6, 5, 8, 8, 131071, 90);
		run_phase(4, 4, 4, 4, 0, 40);
		run_phase(0, 3, 5, 5, 65536, 40);
		for (int p = 0; p < 4; p++)
			run_phase($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(1, 60),
				$urandom_range(1, 60), $urandom_range(8192, 65536), 40);

		if (mismatches == 0 && pending_pixels.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
